FILE: hw/rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the rational fraction ALU
// Opcodes, order codes, field widths and the classification word that the
// front hands to the back through the queue.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int OPC_W = 4;
  localparam int IN_W  = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int ORD_W = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_RED = 4'd4,
    OP_CMP = 4'd5,
    OP_LCD = 4'd6,
    OP_MAX = 4'd7,
    OP_MIN = 4'd8
  } op_t;

  localparam logic [OPC_W-1:0] OP_LAST = 4'd8;

  localparam logic [ORD_W-1:0] ORD_LT = 2'd0;
  localparam logic [ORD_W-1:0] ORD_EQ = 2'd1;
  localparam logic [ORD_W-1:0] ORD_GT = 2'd2;

  // sign bit positions in cls_t.sgn
  localparam int SG_AN = 3;
  localparam int SG_AD = 2;
  localparam int SG_BN = 1;
  localparam int SG_BD = 0;

  typedef struct packed {
    op_t        op;
    logic       op_ok;   // opcode is defined
    logic       err;     // zero denominator / zero divisor
    logic       pos;     // a strictly positive
    logic       neg;     // a strictly negative
    logic [3:0] sgn;     // operand signs, zero counts as positive
  } cls_t;

endpackage

FILE: hw/rtl/rfa_front.sv
// ----------------------------------------------------------------------------
// rfa_front: operand decode and classification
// Splits the four operands into sign and magnitude, checks for zero
// denominators and divisors and derives the sign flags of a.
// ----------------------------------------------------------------------------
module rfa_front #(
  parameter int W = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic [rfa_pkg::OPC_W-1:0]       in_opcode,
  input  logic signed [rfa_pkg::IN_W-1:0] in_a_num,
  input  logic signed [rfa_pkg::IN_W-1:0] in_a_den,
  input  logic signed [rfa_pkg::IN_W-1:0] in_b_num,
  input  logic signed [rfa_pkg::IN_W-1:0] in_b_den,
  output rfa_pkg::cls_t                   cls,
  output logic [W-1:0]                    an_mag,
  output logic [W-1:0]                    ad_mag,
  output logic [W-1:0]                    bn_mag,
  output logic [W-1:0]                    bd_mag
);
  import rfa_pkg::*;

  // operands are taken as W-bit two's complement
  function automatic logic [W:0] smag(logic [IN_W-1:0] raw);
    logic [W-1:0] v;
    v = W'(raw);
    return {v[W-1], (v[W-1] ? -v : v)};
  endfunction

  logic [W:0] an_s, ad_s, bn_s, bd_s;
  logic       op_ok;

  assign an_s = smag($unsigned(in_a_num));
  assign ad_s = smag($unsigned(in_a_den));
  assign bn_s = smag($unsigned(in_b_num));
  assign bd_s = smag($unsigned(in_b_den));

  assign an_mag = an_s[W-1:0];
  assign ad_mag = ad_s[W-1:0];
  assign bn_mag = bn_s[W-1:0];
  assign bd_mag = bd_s[W-1:0];

  assign op_ok = (in_opcode <= OP_LAST);

  always_comb begin
    cls.op    = op_ok ? op_t'(in_opcode) : OP_ADD;
    cls.op_ok = op_ok;
    cls.err   = op_ok && ((ad_mag == '0) ||
                          ((in_opcode != OP_RED) && (bd_mag == '0)) ||
                          ((in_opcode == OP_DIV) && (bn_mag == '0)));
    cls.pos   = (an_mag != '0) && (an_s[W] == ad_s[W]);
    cls.neg   = (an_mag != '0) && (an_s[W] != ad_s[W]);
    cls.sgn   = {an_s[W], ad_s[W], bn_s[W], bd_s[W]};
  end

endmodule

FILE: hw/rtl/rfa_queue.sv
// ----------------------------------------------------------------------------
// rfa_queue: short queue between front and back
// Small circular buffer, registered read data loaded on pop.
// ----------------------------------------------------------------------------
module rfa_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = rfa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] pop_data_r
);
  import rfa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (do_pop) begin
      pop_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/rfa_back.sv
// ----------------------------------------------------------------------------
// rfa_back: sequenced arithmetic engine and result register
// Shared multiplier, binary gcd and a pair of restoring dividers run by a
// one-hot sequencer; one item at a time.
// ----------------------------------------------------------------------------
module rfa_back #(
  parameter int W = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  rfa_pkg::cls_t             q_cls,
  input  logic [W-1:0]              q_an,
  input  logic [W-1:0]              q_ad,
  input  logic [W-1:0]              q_bn,
  input  logic [W-1:0]              q_bd,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [rfa_pkg::NUM_W-1:0] out_res_num,
  output logic [rfa_pkg::DEN_W-1:0] out_res_den,
  output logic [rfa_pkg::DEN_W-1:0] out_second_num,
  output logic [rfa_pkg::ORD_W-1:0] out_order,
  output logic                      out_already_reduced,
  output logic                      out_is_positive,
  output logic                      out_is_negative,
  output logic                      out_error_code
);
  import rfa_pkg::*;

  localparam int M  = 2 * W;
  localparam int CW = $clog2(M + 1);
  localparam int XW = (M > NUM_W) ? M : NUM_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_SETUP = 8'b0000_1000,
    S_GCD   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_MUL2  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t         state_r, state_nxt;
  cls_t           cls_r;
  logic [W-1:0]   an_r, ad_r, bn_r, bd_r;
  logic [M-1:0]   prod_r [5];
  logic [2:0]     mcnt_r;
  logic           rn_neg_r, rd_neg_r;
  logic [M-1:0]   rn_mag_r, rd_mag_r;
  logic [ORD_W-1:0] ord_r;
  logic           red_r, pass_r;
  logic [M-1:0]   gx_r, gy_r, g_r;
  logic [CW-1:0]  gk_r, dcnt_r;
  logic [M-1:0]   dn_r, dd_r;
  logic [M:0]     rmn_r, rmd_r;
  logic           out_valid_r;

  function automatic logic [NUM_W-1:0] tb_num(logic neg, logic [M-1:0] mag);
    logic [XW-1:0] e;
    e = XW'(mag);
    if (neg) e = -e;
    return e[NUM_W-1:0];
  endfunction

  function automatic logic [DEN_W-1:0] tb_den(logic neg, logic [M-1:0] mag);
    logic [XW-1:0] e;
    e = XW'(mag);
    if (neg) e = -e;
    return e[DEN_W-1:0];
  endfunction

  logic sa, sad, sbn, sbd;
  assign sa  = cls_r.sgn[SG_AN];
  assign sad = cls_r.sgn[SG_AD];
  assign sbn = cls_r.sgn[SG_BN];
  assign sbd = cls_r.sgn[SG_BD];

  // shared multiplier
  logic [W-1:0] mul_a, mul_b;
  logic [M-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      unique case (mcnt_r)
        3'd0: begin mul_a = an_r; mul_b = bd_r; end
        3'd1: begin mul_a = bn_r; mul_b = ad_r; end
        3'd2: begin mul_a = ad_r; mul_b = bd_r; end
        3'd3: begin mul_a = an_r; mul_b = bn_r; end
        3'd4: begin mul_a = ad_r; mul_b = bn_r; end
        default: ;
      endcase
    end else if (state_r == S_MUL2) begin
      unique case (mcnt_r)
        3'd0: begin mul_a = dn_r[W-1:0]; mul_b = bd_r; end        // lcd
        3'd1: begin mul_a = an_r;        mul_b = dd_r[W-1:0]; end // a scaled
        3'd2: begin mul_a = bn_r;        mul_b = dn_r[W-1:0]; end // b scaled
        default: ;
      endcase
    end
  end
  assign mul_p = M'(mul_a) * M'(mul_b);

  // signed-magnitude add of the cross products: a*bd +/- b*ad
  logic         xn, yn, sum_neg;
  logic [M-1:0] sum_mag;
  always_comb begin
    xn = sa ^ sbd;
    yn = (sbn ^ sad) ^ (cls_r.op != OP_ADD);
    if (xn == yn) begin
      sum_neg = xn;
      sum_mag = prod_r[0] + prod_r[1];
    end else if (prod_r[0] >= prod_r[1]) begin
      sum_neg = xn;
      sum_mag = prod_r[0] - prod_r[1];
    end else begin
      sum_neg = yn;
      sum_mag = prod_r[1] - prod_r[0];
    end
  end

  logic [ORD_W-1:0] cmp_ord;
  assign cmp_ord = (sum_mag == '0) ? ORD_EQ :
                   ((sum_neg ^ sad ^ sbd) ? ORD_LT : ORD_GT);

  logic cmp_only;
  assign cmp_only = (cls_r.op == OP_CMP) || (cls_r.op == OP_MAX) || (cls_r.op == OP_MIN);

  // binary gcd step
  logic         g_done;
  logic [M-1:0] g_res;
  assign g_done = (gx_r == '0) || (gy_r == '0);
  assign g_res  = ((gx_r == '0) ? gy_r : gx_r) << gk_r;

  // restoring divide step, two dividends over one divisor
  logic [M:0] rn_x, rd_x;
  logic       qn_bit, qd_bit;
  assign rn_x   = {rmn_r[M-1:0], dn_r[M-1]};
  assign rd_x   = {rmd_r[M-1:0], dd_r[M-1]};
  assign qn_bit = (rn_x >= {1'b0, g_r});
  assign qd_bit = (rd_x >= {1'b0, g_r});

  logic out_load;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_pop);
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = (!q_cls.op_ok || q_cls.err) ? S_DONE : S_MUL;
      S_MUL:   if (mcnt_r == 3'd4) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_GCD;
      S_GCD:   begin
        if (g_done) begin
          if (!pass_r && cmp_only) state_nxt = S_DONE;
          else if (pass_r)         state_nxt = S_DIV;
        end
      end
      S_DIV:   begin
        if (dcnt_r == CW'(M - 1))
          state_nxt = (cls_r.op == OP_LCD) ? S_MUL2 : S_DONE;
      end
      S_MUL2:  if (mcnt_r == 3'd2) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        cls_r  <= q_cls;
        an_r   <= q_an;
        ad_r   <= q_ad;
        bn_r   <= q_bn;
        bd_r   <= q_bd;
        mcnt_r <= '0;
      end
      S_MUL: begin
        prod_r[mcnt_r] <= mul_p;
        mcnt_r         <= (mcnt_r == 3'd4) ? 3'd0 : mcnt_r + 3'd1;
      end
      S_SETUP: begin
        ord_r  <= cmp_only ? cmp_ord : ORD_LT;
        gx_r   <= M'(an_r);
        gy_r   <= M'(ad_r);
        gk_r   <= '0;
        pass_r <= 1'b0;
        unique case (cls_r.op)
          OP_ADD, OP_SUB: begin
            rn_neg_r <= sum_neg;
            rn_mag_r <= sum_mag;
            rd_neg_r <= sad ^ sbd;
            rd_mag_r <= prod_r[2];
          end
          OP_MUL: begin
            rn_neg_r <= sa ^ sbn;
            rn_mag_r <= prod_r[3];
            rd_neg_r <= sad ^ sbd;
            rd_mag_r <= prod_r[2];
          end
          OP_DIV: begin
            rn_neg_r <= sa ^ sbd;
            rn_mag_r <= prod_r[0];
            rd_neg_r <= sad ^ sbn;
            rd_mag_r <= prod_r[4];
          end
          OP_RED: begin
            rn_neg_r <= sa;
            rn_mag_r <= M'(an_r);
            rd_neg_r <= sad;
            rd_mag_r <= M'(ad_r);
          end
          OP_LCD: begin
            // gcd of the denominators, quotients give the scale factors
            rn_neg_r <= 1'b0;
            rn_mag_r <= M'(ad_r);
            rd_neg_r <= 1'b0;
            rd_mag_r <= M'(bd_r);
          end
          default: begin
            rn_neg_r <= 1'b0;
            rn_mag_r <= '0;
            rd_neg_r <= sad ^ sbd;
            rd_mag_r <= prod_r[2];
          end
        endcase
      end
      S_GCD: begin
        if (g_done) begin
          if (!pass_r) begin
            red_r  <= (g_res == M'(1));
            gx_r   <= rn_mag_r;
            gy_r   <= rd_mag_r;
            gk_r   <= '0;
            pass_r <= 1'b1;
          end else begin
            g_r    <= g_res;
            dn_r   <= rn_mag_r;
            dd_r   <= rd_mag_r;
            rmn_r  <= '0;
            rmd_r  <= '0;
            dcnt_r <= '0;
          end
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_r <= gx_r >> 1;
          gy_r <= gy_r >> 1;
          gk_r <= gk_r + 1'b1;
        end else if (!gx_r[0]) begin
          gx_r <= gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_r <= gy_r >> 1;
        end else if (gx_r >= gy_r) begin
          gx_r <= gx_r - gy_r;
        end else begin
          gy_r <= gy_r - gx_r;
        end
      end
      S_DIV: begin
        rmn_r  <= qn_bit ? (rn_x - {1'b0, g_r}) : rn_x;
        rmd_r  <= qd_bit ? (rd_x - {1'b0, g_r}) : rd_x;
        dn_r   <= {dn_r[M-2:0], qn_bit};
        dd_r   <= {dd_r[M-2:0], qd_bit};
        dcnt_r <= dcnt_r + 1'b1;
        mcnt_r <= '0;
      end
      S_MUL2: begin
        prod_r[mcnt_r] <= mul_p;
        mcnt_r         <= mcnt_r + 3'd1;
      end
      default: ;
    endcase
  end

  // result formation
  logic [NUM_W-1:0] f_num;
  logic [DEN_W-1:0] f_den, f_sec;
  logic [ORD_W-1:0] f_ord;
  logic             f_red, f_pos, f_neg, f_err, pick_a;

  always_comb begin
    f_num  = '0;
    f_den  = '0;
    f_sec  = '0;
    f_ord  = ORD_LT;
    f_red  = 1'b0;
    f_pos  = 1'b0;
    f_neg  = 1'b0;
    f_err  = 1'b0;
    pick_a = 1'b0;
    if (cls_r.op_ok && cls_r.err) begin
      f_err = 1'b1;
    end else if (cls_r.op_ok) begin
      f_red = red_r;
      f_pos = cls_r.pos;
      f_neg = cls_r.neg;
      unique case (cls_r.op)
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_RED: begin
          f_num = tb_num(rn_neg_r, dn_r);
          f_den = tb_den(rd_neg_r, dd_r);
        end
        OP_LCD: begin
          f_den = tb_den(1'b0, prod_r[0]);
          f_num = tb_num(sa ^ sad, prod_r[1]);
          f_sec = tb_den(sbn ^ sbd, prod_r[2]);
        end
        OP_CMP: begin
          f_ord = ord_r;
        end
        OP_MAX, OP_MIN: begin
          f_ord  = ord_r;
          pick_a = (cls_r.op == OP_MAX) ? (ord_r == ORD_GT) : (ord_r == ORD_LT);
          f_num  = pick_a ? tb_num(sa, M'(an_r))  : tb_num(sbn, M'(bn_r));
          f_den  = pick_a ? tb_den(sad, M'(ad_r)) : tb_den(sbd, M'(bd_r));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_num         <= f_num;
      out_res_den         <= f_den;
      out_second_num      <= f_sec;
      out_order           <= f_ord;
      out_already_reduced <= f_red;
      out_is_positive     <= f_pos;
      out_is_negative     <= f_neg;
      out_error_code      <= f_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_empty = !out_valid_r;

endmodule

FILE: hw/rtl/rational_fraction_alu_core.sv
// Sequence: errors and unused opcodes go from load straight to done; compare, max, min add
//   5 multiplies and one gcd pass over a; other opcodes add a gcd pass on
//   2*OPERAND_WIDTH-bit values and a 2*OPERAND_WIDTH-bit restoring divide,
//   common denominator 3 more multiplies.
// Throughput: one beat at a time in the back engine; gcd loop and divider set it.
// Reset (rst_n low, synchronous) empties the input queue and the result register.
// ----------------------------------------------------------------------------
// rational_fraction_alu_core: exact arithmetic on two signed fractions
// Front decode feeds a short queue; the back engine reduces by gcd, compares
// exactly and rewrites over the least common denominator.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core #(
  parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = rfa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beats
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [rfa_pkg::OPC_W-1:0]        in_opcode,
  input  logic signed [rfa_pkg::IN_W-1:0]  in_a_num,
  input  logic signed [rfa_pkg::IN_W-1:0]  in_a_den,
  input  logic signed [rfa_pkg::IN_W-1:0]  in_b_num,
  input  logic signed [rfa_pkg::IN_W-1:0]  in_b_den,
  // result beats
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic signed [rfa_pkg::NUM_W-1:0] out_res_num,
  output logic signed [rfa_pkg::DEN_W-1:0] out_res_den,
  output logic signed [rfa_pkg::DEN_W-1:0] out_second_num,
  output logic [rfa_pkg::ORD_W-1:0]        out_order,
  output logic                             out_already_reduced,
  output logic                             out_is_positive,
  output logic                             out_is_negative,
  output logic                             out_error_code
);
  import rfa_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = $bits(cls_t) + 4 * W;

  // front: classify the beat as it arrives
  cls_t         f_cls;
  logic [W-1:0] f_an, f_ad, f_bn, f_bd;

  rfa_front #(.W(W)) u_front (
    .in_opcode (in_opcode),
    .in_a_num  (in_a_num),
    .in_a_den  (in_a_den),
    .in_b_num  (in_b_num),
    .in_b_den  (in_b_den),
    .cls       (f_cls),
    .an_mag    (f_an),
    .ad_mag    (f_ad),
    .bn_mag    (f_bn),
    .bd_mag    (f_bd)
  );

  // queue decouples the front from the slow back engine
  logic [DW-1:0] q_wdata, q_rdata;
  logic          q_empty, q_pop;
  cls_t          q_cls;
  logic [W-1:0]  q_an, q_ad, q_bn, q_bd;

  assign q_wdata = {f_cls, f_an, f_ad, f_bn, f_bd};
  assign {q_cls, q_an, q_ad, q_bn, q_bd} = q_rdata;

  rfa_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .push_data  (q_wdata),
    .full       (in_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .pop_data_r (q_rdata)
  );

  // back: sequenced engine plus result register
  rfa_back #(.W(W)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_cls               (q_cls),
    .q_an                (q_an),
    .q_ad                (q_ad),
    .q_bn                (q_bn),
    .q_bd                (q_bd),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_res_num         (out_res_num),
    .out_res_den         (out_res_den),
    .out_second_num      (out_second_num),
    .out_order           (out_order),
    .out_already_reduced (out_already_reduced),
    .out_is_positive     (out_is_positive),
    .out_is_negative     (out_is_negative),
    .out_error_code      (out_error_code)
  );

  // an error beat carries nothing but the error code
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error_code) |->
      (out_res_num == '0 && out_res_den == '0 && out_second_num == '0))
    else $error("error result with nonzero payload");

  // a cannot be both positive and negative, nor flagged on an error
  a_sign_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_is_positive && out_is_negative) &&
                   !(out_error_code && (out_is_positive || out_is_negative)))
    else $error("inconsistent sign flags");

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_res_num) &&
                                  $stable(out_res_den)))
    else $error("result changed while waiting");

endmodule

FILE: verif/tb_rational_fraction_alu_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_fraction_alu_core: self-checking bench for the fraction ALU
// Directed corner beats, one long output hold-off, then random beats with random
// push/pop gaps. Every result is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_rational_fraction_alu_core;
  import rfa_pkg::*;

  // one predicted result beat
  typedef struct {
    logic signed [NUM_W-1:0] res_num;
    logic signed [DEN_W-1:0] res_den;
    logic signed [DEN_W-1:0] second_num;
    logic [ORD_W-1:0]        order;
    logic                    reduced;
    logic                    pos;
    logic                    neg;
    logic                    err;
  } frac_res_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [OPC_W-1:0] in_opcode = '0;
  logic signed [IN_W-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [NUM_W-1:0] out_res_num;
  logic signed [DEN_W-1:0] out_res_den, out_second_num;
  logic [ORD_W-1:0] out_order;
  logic out_already_reduced, out_is_positive, out_is_negative, out_error_code;

  frac_res_t pending_results[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;

  rational_fraction_alu_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint gcd_mag(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // divide both by gcd of magnitudes; signs stay where they fell
  function automatic void reduce_pair(inout longint n, inout longint d);
    longint g;
    g = gcd_mag(mag(n), mag(d));
    if (g != 0) begin
      n = n / g;
      d = d / g;
    end
  endfunction

  function automatic frac_res_t predict_fraction(logic [OPC_W-1:0] op,
      logic signed [IN_W-1:0] a_n, logic signed [IN_W-1:0] a_d,
      logic signed [IN_W-1:0] b_n, logic signed [IN_W-1:0] b_d);
    frac_res_t r;
    longint an, ad, bn, bd, n, d, s, l, diff;
    an = a_n; ad = a_d; bn = b_n; bd = b_d;
    n = 0; d = 0; s = 0;
    r = '{default: '0};
    if (op > OP_LAST) return r;
    if (ad == 0 || (op != OP_RED && bd == 0) || (op == OP_DIV && bn == 0)) begin
      r.err = 1'b1;
      return r;
    end
    case (op)
      OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; reduce_pair(n, d); end
      OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; reduce_pair(n, d); end
      OP_MUL: begin n = an * bn; d = ad * bd; reduce_pair(n, d); end
      OP_DIV: begin n = an * bd; d = ad * bn; reduce_pair(n, d); end
      OP_RED: begin n = an; d = ad; reduce_pair(n, d); end
      OP_LCD: begin
        l = (mag(ad) / gcd_mag(mag(ad), mag(bd))) * mag(bd);
        n = an * ((ad < 0) ? -(l / mag(ad)) : l / mag(ad));
        s = bn * ((bd < 0) ? -(l / mag(bd)) : l / mag(bd));
        d = l;
      end
      default: begin
        // sign of a-b is diff's sign flipped when the denominators' product is negative
        diff = an * bd - bn * ad;
        if (diff == 0) r.order = ORD_EQ;
        else r.order = ((diff < 0) != ((ad < 0) != (bd < 0))) ? ORD_LT : ORD_GT;
        if ((op == OP_MAX && r.order == ORD_GT) || (op == OP_MIN && r.order == ORD_LT)) begin
          n = an; d = ad;
        end else if (op != OP_CMP) begin
          n = bn; d = bd;
        end
      end
    endcase
    r.res_num    = n[NUM_W-1:0];
    r.res_den    = d[DEN_W-1:0];
    r.second_num = s[DEN_W-1:0];
    r.reduced    = (gcd_mag(mag(an), mag(ad)) == 1);
    r.pos        = (an != 0) && ((an < 0) == (ad < 0));
    r.neg        = (an != 0) && ((an < 0) != (ad < 0));
    return r;
  endfunction

  // present one beat after a random gap, unless no_gap is set, and hold it until accepted;
  // push stays high afterwards so that back to back beats need no extra edge
  task automatic send_fraction(logic [OPC_W-1:0] op, logic signed [IN_W-1:0] a_n,
      logic signed [IN_W-1:0] a_d, logic signed [IN_W-1:0] b_n,
      logic signed [IN_W-1:0] b_d, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_opcode <= op;
    in_a_num  <= a_n;
    in_a_den  <= a_d;
    in_b_num  <= b_n;
    in_b_den  <= b_d;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_results.push_back(predict_fraction(op, a_n, a_d, b_n, b_d));
  endtask

  function automatic logic signed [IN_W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom);                                // full range
      1: return IN_W'(32'h0000_8000 + $urandom_range(0, 2));    // most negative end
      2: return IN_W'(32'h0000_7FFF - $urandom_range(0, 2));    // most positive end
      3: return IN_W'($urandom_range(0, 2) - 1);                // -1, 0, 1
      default: return IN_W'($urandom_range(0, 40) - 20);        // small, shares factors
    endcase
  endfunction

  task automatic test_directed();
    logic signed [IN_W-1:0] mx, mn;
    mx = 16'sh7FFF;
    mn = 16'sh8000;
    send_fraction(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_fraction(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);      // zero numerator
    send_fraction(OP_MUL, mn, mn, mn, mn);
    send_fraction(OP_DIV, mx, mn, mn, mx);
    send_fraction(OP_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);      // zero divisor
    send_fraction(OP_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd5);      // zero denominator in a
    send_fraction(OP_ADD, 16'sd3, 16'sd4, 16'sd1, 16'sd0);      // zero denominator in b
    send_fraction(OP_RED, 16'sd6, -16'sd8, 16'sd0, 16'sd0);     // b ignored by reduce
    send_fraction(OP_RED, 16'sd0, -16'sd7, 16'sd1, 16'sd1);
    send_fraction(OP_RED, 16'sd5, 16'sd0, 16'sd1, 16'sd1);
    send_fraction(OP_CMP, 16'sd1, 16'sd2, -16'sd2, -16'sd4);    // equal
    send_fraction(OP_CMP, -16'sd1, 16'sd3, 16'sd1, -16'sd4);
    send_fraction(OP_MAX, 16'sd2, 16'sd3, 16'sd4, 16'sd6);      // tie returns b
    send_fraction(OP_MIN, 16'sd2, 16'sd3, 16'sd4, 16'sd6);
    send_fraction(OP_MAX, mx, 16'sd1, mn, 16'sd1);
    send_fraction(OP_MIN, mx, -16'sd1, 16'sd1, mn);
    send_fraction(OP_LCD, 16'sd1, -16'sd6, 16'sd5, 16'sd4);
    send_fraction(OP_LCD, mx, mn, mn, mx);
    send_fraction(OP_SUB, mn, 16'sh0001, mx, 16'shFFFF);
    send_fraction(4'd9, 16'sd1, 16'sd1, 16'sd1, 16'sd1);        // unused opcodes
    send_fraction(4'd15, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
  endtask

  task automatic test_random(int count);
    logic [OPC_W-1:0] op;
    repeat (count) begin
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      send_fraction(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  // output held off while input keeps pushing back to back
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (12) send_fraction(4'($urandom_range(0, 8)), rand_operand(), rand_operand(),
                                rand_operand(), rand_operand(), 1'b1);
    join
  endtask

  // result side: random pop gaps, compare each accepted beat with the oldest prediction
  initial begin : result_check
    frac_res_t exp_r;
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_off) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if ({out_res_num, out_res_den, out_second_num, out_order, out_already_reduced,
             out_is_positive, out_is_negative, out_error_code} !==
            {exp_r.res_num, exp_r.res_den, exp_r.second_num, exp_r.order, exp_r.reduced,
             exp_r.pos, exp_r.neg, exp_r.err}) begin
          $display("%0t: mismatch exp num=%0d den=%0d sec=%0d ord=%0d red=%0b p=%0b n=%0b e=%0b",
                   $time, exp_r.res_num, exp_r.res_den, exp_r.second_num, exp_r.order,
                   exp_r.reduced, exp_r.pos, exp_r.neg, exp_r.err);
          $display("%0t:          act num=%0d den=%0d sec=%0d ord=%0d red=%0b p=%0b n=%0b e=%0b",
                   $time, out_res_num, out_res_den, out_second_num, out_order,
                   out_already_reduced, out_is_positive, out_is_negative, out_error_code);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1230);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
